// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core of the decimal text formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ftd_pkg.sv =====
// Shared types, constants and tables for the float-to-decimal-text formatter.
package ftd_pkg;

    // Default count of fraction digits allowed.
    localparam int MAX_FRAC_DEFAULT = 10;

    // The integer part holds up to ten decimal digits.
    localparam int INT_DIGITS = 10;
    localparam int CNT_W      = 4;

    // ASCII characters used in the text.
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;

    // Reciprocal of ten: floor(x / 10) = (x * RECIP10) >> 35 for any 32-bit x.
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    // Saturated integer part.
    localparam logic [31:0] IPART_MAX = 32'hFFFF_FFFF;

    // Decoded value in 32.48 unsigned fixed point plus its flags.
    typedef struct packed {
        logic [31:0] ipart;
        logic [47:0] frac;
        logic        ovf;
        logic        show_sign;
    } dec_t;

    // Rounding addend floor(2^47 / 10^p) in units of 2^-48.
    function automatic logic [47:0] half_ulp(input logic [3:0] p);
        logic [47:0] r;
        unique case (p)
            4'd1:    r = 48'd14073748835532;
            4'd2:    r = 48'd1407374883553;
            4'd3:    r = 48'd140737488355;
            4'd4:    r = 48'd14073748835;
            4'd5:    r = 48'd1407374883;
            4'd6:    r = 48'd140737488;
            4'd7:    r = 48'd14073748;
            4'd8:    r = 48'd1407374;
            4'd9:    r = 48'd140737;
            4'd10:   r = 48'd14073;
            4'd11:   r = 48'd1407;
            4'd12:   r = 48'd140;
            4'd13:   r = 48'd14;
            4'd14:   r = 48'd1;
            default: r = 48'd0;
        endcase
        return r;
    endfunction

    // Automatic precision picked from the size of the integer part.
    function automatic logic [2:0] auto_prec(input logic [31:0] ip);
        logic [2:0] p;
        priority if (ip < 32'd1)      p = 3'd6;
        else if (ip < 32'd10)         p = 3'd5;
        else if (ip < 32'd100)        p = 3'd4;
        else if (ip < 32'd1000)       p = 3'd3;
        else if (ip < 32'd10000)      p = 3'd2;
        else if (ip < 32'd100000)     p = 3'd1;
        else                          p = 3'd0;
        return p;
    endfunction

endpackage

// ===== rtl/ftd_decode.sv =====
// Unpacks an IEEE single into 32.48 unsigned fixed point with saturation and sign flags.
module ftd_decode (
    input  logic [31:0]   value_bits,
    output ftd_pkg::dec_t dec
);
    import ftd_pkg::*;

    logic [7:0]  expo;
    logic [22:0] man;
    logic        is_nan;
    logic        sat;
    logic [79:0] mant_ext;
    logic [79:0] fixed;
    logic [6:0]  lsh;
    logic [7:0]  rsh;

    assign expo     = value_bits[30:23];
    assign man      = value_bits[22:0];
    assign is_nan   = (expo == 8'hFF) && (man != 23'd0);
    assign sat      = (expo >= 8'd159);
    assign mant_ext = {56'd0, 1'b1, man};
    assign lsh      = 7'(expo - 8'd102);
    assign rsh      = 8'd102 - expo;

    // Align the mantissa so that bit 48 weighs one.
    always_comb
    begin
        if (expo >= 8'd102)
        begin
            fixed = mant_ext << lsh;
        end
        else
        begin
            fixed = mant_ext >> rsh;
        end
    end

    // Saturate large values, infinity and NaN; zeros and subnormals give zero.
    always_comb
    begin
        dec.ovf       = sat;
        dec.show_sign = value_bits[31] && !is_nan && (value_bits[30:0] != 31'd0);
        if (sat)
        begin
            dec.ipart = IPART_MAX;
            dec.frac  = 48'd0;
        end
        else if (expo == 8'd0)
        begin
            dec.ipart = 32'd0;
            dec.frac  = 48'd0;
        end
        else
        begin
            dec.ipart = fixed[79:48];
            dec.frac  = fixed[47:0];
        end
    end

endmodule

// ===== rtl/float_to_decimal_text_core.sv =====
// Float-to-decimal-text formatter: sequencer, divide-by-ten loop and character output.
// A sign beat, if any, follows the auto, round and carry steps; each of the n integer
// digits then takes one S_DIVM and S_DIVF pass of the shared divider. The digits follow,
// most significant first, then the point and p fraction digits (neither when p is zero);
// busy stays high until the last beat, and the next start goes with it.
// Reset (rst_n low, asynchronous) returns to idle with no strobe; the receiver cannot stall.
module float_to_decimal_text_core #(
    parameter int MAX_FRACTION_DIGITS = ftd_pkg::MAX_FRAC_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       value_bits,
    input  logic signed [4:0] digits,
    output logic              strobe,
    output logic [6:0]        char_code,
    output logic              last,
    output logic              overflow
);
    import ftd_pkg::*;

    `include "assert_macros.svh"

    localparam int PREC_MAX = (MAX_FRACTION_DIGITS > 6) ? MAX_FRACTION_DIGITS : 6;
    localparam int PREC_W   = $clog2(PREC_MAX + 1);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AUTO  = 4'd1;
    localparam logic [3:0] S_ROUND = 4'd2;
    localparam logic [3:0] S_INC   = 4'd3;
    localparam logic [3:0] S_DIVM  = 4'd4;
    localparam logic [3:0] S_DIVF  = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_DOT   = 4'd7;
    localparam logic [3:0] S_FRAC  = 4'd8;

    dec_t dec;

    logic [3:0]        state_reg, state_next;
    logic [31:0]       ipart_reg, ipart_next;
    logic [47:0]       frac_reg, frac_next;
    logic              ovf_reg, ovf_next;
    logic              sign_reg, sign_next;
    logic              auto_reg, auto_next;
    logic              carry_reg, carry_next;
    logic [PREC_W-1:0] prec_reg, prec_next;
    logic [PREC_W-1:0] fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [63:0]       prod_reg, prod_next;
    logic [6:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic              strobe_reg, strobe_next;

    logic [3:0]        dig_mem [0:INT_DIGITS-1];

    logic [31:0]       quo;
    logic [31:0]       rem_full;
    logic [48:0]       round_sum;
    logic [51:0]       frac_x10;
    logic [PREC_W-1:0] prec_clamped;

    ftd_decode u_decode (
        .value_bits (value_bits),
        .dec        (dec)
    );

    // Quotient and remainder of the integer part from the registered product.
    assign quo      = {{RECIP_SHIFT - 32{1'b0}}, prod_reg[63:RECIP_SHIFT]};
    assign rem_full = ipart_reg - ({quo[28:0], 3'b000} + {quo[30:0], 1'b0});

    // Rounding add and the times-ten step for fraction digits.
    assign round_sum = {1'b0, frac_reg} + {1'b0, half_ulp(4'(prec_reg))};
    assign frac_x10  = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0};

    // Requested precision limited to the maximum.
    always_comb
    begin
        if ({28'd0, digits[3:0]} > 32'(MAX_FRACTION_DIGITS))
        begin
            prec_clamped = PREC_W'(MAX_FRACTION_DIGITS);
        end
        else
        begin
            prec_clamped = PREC_W'(digits[3:0]);
        end
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next  = state_reg;
        ipart_next  = ipart_reg;
        frac_next   = frac_reg;
        ovf_next    = ovf_reg;
        sign_next   = sign_reg;
        auto_next   = auto_reg;
        carry_next  = carry_reg;
        prec_next   = prec_reg;
        fcnt_next   = fcnt_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        char_next   = char_reg;
        last_next   = 1'b0;
        strobe_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ipart_next = dec.ipart;
                    frac_next  = dec.frac;
                    ovf_next   = dec.ovf;
                    sign_next  = dec.show_sign;
                    auto_next  = digits[4];
                    prec_next  = prec_clamped;
                    cnt_next   = '0;
                    state_next = S_AUTO;
                end
            end
            S_AUTO:
            begin
                if (auto_reg)
                begin
                    prec_next = PREC_W'(auto_prec(ipart_reg));
                end
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (prec_reg != '0)
                begin
                    frac_next  = round_sum[47:0];
                    carry_next = round_sum[48];
                end
                else
                begin
                    carry_next = 1'b0;
                end
                state_next = S_INC;
            end
            S_INC:
            begin
                if (carry_reg && (ipart_reg != IPART_MAX))
                begin
                    ipart_next = ipart_reg + 32'd1;
                end
                if (sign_reg)
                begin
                    strobe_next = 1'b1;
                    char_next   = CH_MINUS;
                end
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                prod_next  = ipart_reg * RECIP10;
                state_next = S_DIVF;
            end
            S_DIVF:
            begin
                ipart_next = quo;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = (quo == 32'd0) ? S_EMIT : S_DIVM;
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = CH_ZERO + {3'b000, dig_mem[cnt_reg - CNT_W'(1)]};
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    if (prec_reg == '0)
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DOT;
                    end
                end
            end
            S_DOT:
            begin
                strobe_next = 1'b1;
                char_next   = CH_DOT;
                fcnt_next   = prec_reg;
                state_next  = S_FRAC;
            end
            S_FRAC:
            begin
                strobe_next = 1'b1;
                char_next   = CH_ZERO + {3'b000, frac_x10[51:48]};
                frac_next   = frac_x10[47:0];
                fcnt_next   = fcnt_reg - PREC_W'(1);
                if (fcnt_reg == PREC_W'(1))
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ipart_reg  <= '0;
            frac_reg   <= '0;
            ovf_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            auto_reg   <= 1'b0;
            carry_reg  <= 1'b0;
            prec_reg   <= '0;
            fcnt_reg   <= '0;
            cnt_reg    <= '0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ipart_reg  <= ipart_next;
            frac_reg   <= frac_next;
            ovf_reg    <= ovf_next;
            sign_reg   <= sign_next;
            auto_reg   <= auto_next;
            carry_reg  <= carry_next;
            prec_reg   <= prec_next;
            fcnt_reg   <= fcnt_next;
            cnt_reg    <= cnt_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
            strobe_reg <= strobe_next;
        end
    end

    // Product register of the divide-by-ten unit.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Integer digits are stored least significant first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIVF)
        begin
            dig_mem[cnt_reg] <= rem_full[3:0];
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign overflow  = ovf_reg;

    // An accepted beat starts the sequencer.
    `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not start the sequencer")
    // The digit buffer never overfills.
    `ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(INT_DIGITS), "integer digit count out of range")
    // The last character ends the item and returns to idle.
    `ASSERT_ALWAYS(a_last_idle, !(strobe_reg && last_reg) || (state_reg == S_IDLE), "last beat while still busy")
    // Last is only flagged on a strobed beat.
    `ASSERT_ALWAYS(a_last_strobe, !last_reg || strobe_reg, "last flag without strobe")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the float-to-decimal-text formatter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftd_pkg::*;

    localparam int MAX_FRACTION_DIGITS = MAX_FRAC_DEFAULT;
    localparam int RANDOM_NUMBERS      = 125;
    localparam int IDLE_LIMIT          = 500;
    localparam int DRAIN_CYCLES        = 60;
    localparam logic [63:0] FRAC_ONE   = 64'd1 << 48;

    // One number waiting to be sent, with the idle cycles that come before it.
    typedef struct {
        logic [31:0]       value;
        logic signed [4:0] prec;
        int                gap;
    } number_t;

    // One character of the expected text.
    typedef struct {
        logic [6:0] code;
        logic       last;
        logic       ovf;
    } text_char_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [31:0]       value_bits;
    logic signed [4:0] digits;
    logic              strobe;
    logic [6:0]        char_code;
    logic              last;
    logic              overflow;

    number_t    pending_numbers[$];
    text_char_t expected_text[$];

    int  numbers_total  = 0;
    int  numbers_taken  = 0;
    int  chars_checked  = 0;
    int  ovf_chars      = 0;
    int  error_count    = 0;
    int  idle_cycles    = 0;
    logic beat_taken    = 1'b0;

    // Driver state, touched only by the driver process.
    number_t staged_number;
    logic    staged = 1'b0;
    int      hold_cnt = 0;

    float_to_decimal_text_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value_bits (value_bits),
        .digits     (digits),
        .strobe     (strobe),
        .char_code  (char_code),
        .last       (last),
        .overflow   (overflow)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Work out the decimal text of one number and queue its characters.
    function automatic void predict_text(input logic [31:0] bits,
                                         input logic signed [4:0] dig);
        logic [7:0]  expo;
        logic [22:0] man;
        logic        is_nan;
        logic        ovf;
        logic [63:0] ipart;
        logic [63:0] frac;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] addend;
        logic [63:0] t;
        logic [3:0]  int_digits[12];
        int          e;
        int          sh;
        int          prec;
        int          n;
        text_char_t  line[$];
        text_char_t  c;

        expo   = bits[30:23];
        man    = bits[22:0];
        is_nan = (expo == 8'hFF) && (man != 23'd0);
        ovf    = 1'b0;
        ipart  = 64'd0;
        frac   = 64'd0;
        rem    = 64'd0;

        // Convert the magnitude to 32.48 fixed point, saturating on overflow.
        if (expo == 8'hFF || expo >= 8'd159)
        begin
            ovf   = 1'b1;
            ipart = 64'hFFFF_FFFF;
        end
        else if (expo != 8'd0)
        begin
            mant = {40'd0, 1'b1, man};
            e    = int'(expo) - 150;
            if (e >= 0)
            begin
                ipart = mant << e;
            end
            else
            begin
                sh = -e;
                if (sh < 24)
                begin
                    ipart = mant >> sh;
                    rem   = mant & ((64'd1 << sh) - 64'd1);
                end
                else
                begin
                    rem = mant;
                end
                if (sh <= 48)
                    frac = rem << (48 - sh);
                else if (sh - 48 < 64)
                    frac = rem >> (sh - 48);
            end
        end

        prec = int'(dig);
        if (prec > MAX_FRACTION_DIGITS)
            prec = MAX_FRACTION_DIGITS;

        // Sign is dropped for zeros of either sign and for NaN.
        if (bits[31] && !is_nan && bits[30:0] != 31'd0)
        begin
            c = '{code: CH_MINUS, last: 1'b0, ovf: ovf};
            line.push_back(c);
        end

        // Automatic precision from the size of the integer part.
        if (prec < 0)
        begin
            if (ipart < 1)           prec = 6;
            else if (ipart < 10)     prec = 5;
            else if (ipart < 100)    prec = 4;
            else if (ipart < 1000)   prec = 3;
            else if (ipart < 10000)  prec = 2;
            else if (ipart < 100000) prec = 1;
            else                     prec = 0;
        end

        // Round by half a unit of the last fraction digit.
        if (prec > 0)
        begin
            addend = 64'd1 << 47;
            for (int i = 0; i < prec; i++)
                addend = addend / 10;
            frac = frac + addend;
            if (frac >= FRAC_ONE)
            begin
                frac  = frac - FRAC_ONE;
                ipart = ipart + 1;
                if (ipart > 64'hFFFF_FFFF)
                    ipart = 64'hFFFF_FFFF;
            end
        end

        // Integer digits, most significant first.
        if (ipart == 0)
        begin
            c = '{code: CH_ZERO, last: 1'b0, ovf: ovf};
            line.push_back(c);
        end
        else
        begin
            n = 0;
            while (ipart != 0 && n < 12)
            begin
                int_digits[n] = 4'(ipart % 10);
                ipart = ipart / 10;
                n++;
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                c = '{code: CH_ZERO + 7'(int_digits[i]), last: 1'b0, ovf: ovf};
                line.push_back(c);
            end
        end

        // Point and fraction digits, truncated.
        if (prec > 0)
        begin
            c = '{code: CH_DOT, last: 1'b0, ovf: ovf};
            line.push_back(c);
            for (int i = 0; i < prec; i++)
            begin
                t    = frac * 10;
                frac = t & (FRAC_ONE - 64'd1);
                c = '{code: CH_ZERO + 7'(t >> 48), last: 1'b0, ovf: ovf};
                line.push_back(c);
            end
        end

        line[line.size() - 1].last = 1'b1;
        foreach (line[i])
            expected_text.push_back(line[i]);
    endfunction

    // Queue one number for the driver.
    task automatic add_number(input logic [31:0] value, input logic [4:0] prec,
                              input int gap);
        number_t num;
        num.value = value;
        num.prec  = prec;
        num.gap   = gap;
        pending_numbers.push_back(num);
        numbers_total++;
    endtask

    // Driver: presents numbers at the falling edge and holds each until taken.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !beat_taken))
        begin
            if (!staged && pending_numbers.size() != 0)
            begin
                staged_number = pending_numbers.pop_front();
                staged        = 1'b1;
                hold_cnt      = staged_number.gap;
            end
            if (staged && hold_cnt == 0)
            begin
                value_bits <= staged_number.value;
                digits     <= staged_number.prec;
                start      <= 1'b1;
                staged      = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                if (staged)
                    hold_cnt--;
            end
        end
    end

    // Monitor: takes input beats, checks each character and runs the watchdog.
    always @(posedge clk)
    begin
        text_char_t want;
        beat_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_text(value_bits, digits);
                numbers_taken++;
            end

            if (strobe)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h", char_code));
                end
                else
                begin
                    want = expected_text.pop_front();
                    chars_checked++;
                    if (want.ovf)
                        ovf_chars++;
                    if (char_code !== want.code)
                        report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                                  char_code, want.code));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %b, wanted %b", last, want.last));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %b, wanted %b",
                                                  overflow, want.ovf));
                end
            end

            // Watchdog on cycles with no beat in either direction.
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [31:0] v;
        logic [4:0]  p;
        int          gap;

        rst_n      = 1'b0;
        start      = 1'b0;
        value_bits = 32'd0;
        digits     = 5'sd0;

        // Directed numbers: zeros, extremes, special values and precision corners.
        add_number(32'h0000_0000, 5'd0,  0);   // zero, no fraction
        add_number(32'h8000_0000, 5'd3,  0);   // negative zero prints unsigned
        add_number(32'h3F80_0000, 5'h1F, 2);   // 1.0, automatic precision
        add_number(32'h3F80_0000, 5'h10, 0);   // most negative precision code
        add_number(32'hBFC0_0000, 5'd15, 0);   // -1.5, precision clamped
        add_number(32'h3F80_0000, 5'd11, 1);   // just above the clamp
        add_number(32'h3F00_0000, 5'd0,  0);   // 0.5 truncated without rounding
        add_number(32'h4118_0000, 5'd0,  3);   // 9.5 truncated
        add_number(32'h3F7F_FFEF, 5'd2,  0);   // rounding carries into integer part
        add_number(32'h42F6_E979, 5'h1F, 0);   // 123.456, automatic
        add_number(32'h4640_E6B6, 5'h1F, 0);   // 12345.678, automatic
        add_number(32'h47C3_4F80, 5'h1F, 0);   // 99999, automatic one digit
        add_number(32'h47C3_5000, 5'h1F, 5);   // 100000, automatic none
        add_number(32'h4E6E_6B28, 5'd1,  0);   // one billion
        add_number(32'h4F7F_FFFF, 5'd10, 0);   // largest value below 2^32
        add_number(32'h4F80_0000, 5'd2,  16);  // 2^32 saturates
        add_number(32'h7F80_0000, 5'h1F, 0);   // +infinity
        add_number(32'hFF80_0000, 5'd1,  0);   // -infinity keeps the sign
        add_number(32'h7FC0_0000, 5'd4,  0);   // NaN
        add_number(32'hFFFF_FFFF, 5'd2,  0);   // negative NaN prints unsigned
        add_number(32'h7F7F_FFFF, 5'd15, 0);   // largest finite value
        add_number(32'h0000_0001, 5'd5,  0);   // subnormal becomes zero
        add_number(32'h8000_0001, 5'd5,  0);   // negative subnormal keeps '-'
        add_number(32'h0080_0000, 5'd10, 0);   // smallest normal
        add_number(32'hB3D6_BF95, 5'd3,  0);   // tiny negative prints as -0.000

        // Random numbers: mostly in the printable range, some raw bit patterns.
        for (int n = 0; n < RANDOM_NUMBERS; n++)
        begin
            v = $urandom;
            if ($urandom_range(0, 3) != 0)
                v[30:23] = 8'($urandom_range(100, 160));
            p = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 2) == 0)
                p = 5'($urandom_range(0, MAX_FRACTION_DIGITS));
            // Alternate between back-to-back bursts and random gaps.
            gap = ((n / 20) % 3 == 0) ? 0 : $urandom_range(0, 16);
            add_number(v, p, gap);
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Wait for every number to be taken and every character to arrive.
        while (numbers_taken < numbers_total || expected_text.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d numbers (%0d directed), checked %0d characters.",
                 numbers_taken, numbers_total - RANDOM_NUMBERS, chars_checked);
        $display("Saturated characters seen: %0d; mismatches: %0d.",
                 ovf_chars, error_count);
        if (error_count == 0 && expected_text.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
